// ===== hw/rtl/tpc_pkg.sv =====
// ----------------------------------------------------------------------------
// tpc_pkg: shared constants for the triangle plane clipper
// Widths, register indexes, plane register reset values and the clip modes.
// ----------------------------------------------------------------------------
package tpc_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int FRAC_BITS   = 16;

	// configuration register indexes
	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_POINT_X  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_POINT_Y  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_POINT_Z  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_NORMAL_X = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_NORMAL_Y = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_NORMAL_Z = 3'd5;

	// reset values, cut to the coordinate width where used
	localparam logic [63:0] POINT_Z_RESET  = 64'd6554;   // 0.1
	localparam logic [63:0] NORMAL_Z_RESET = 64'd65536;  // 1.0

	// clip outcome of one triangle
	localparam logic [1:0] MODE_NONE = 2'd0;  // nothing emitted
	localparam logic [1:0] MODE_ALL  = 2'd1;  // triangle unchanged
	localparam logic [1:0] MODE_ONE  = 2'd2;  // one vertex inside
	localparam logic [1:0] MODE_TWO  = 2'd3;  // two vertices inside

endpackage

// ===== hw/rtl/triangle_plane_clip.sv =====
// ----------------------------------------------------------------------------
// triangle_plane_clip: clips one triangle against a configurable plane
// Setup sequencer for the unit normal plus a 13-stage clip pipeline.
// ----------------------------------------------------------------------------
// A triangle beat can be accepted every cycle unless setup runs or the output
// stalls; results pass through s1 to s13 into the output register. A triangle
// entirely inside gives one result beat, one with a single vertex inside
// gives one shrunk triangle, one with two vertices inside gives two beats
// back to back (last_of_run marks the second), and one fully outside, or any
// triangle while the normal is zero, gives no beat. The output register is
// the only point of contention: a split result holds it until both beats are
// taken, so the sustained rate is one input per cycle for single results;
// split ones stall the pipeline for their second beat. After reset and after
// every configuration write a setup pass normalizes the plane normal (sum of
// squares, bit-serial square root, three bit-serial divisions, plane offset);
// in_ready is low during that pass. Write registers only while idle.
module triangle_plane_clip #(
	parameter int COORD_WIDTH = tpc_pkg::COORD_WIDTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [tpc_pkg::REG_IDX_W-1:0]    cfg_index,
	input  logic [COORD_WIDTH-1:0]           cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [COORD_WIDTH-1:0]    vertex0_x,
	input  logic signed [COORD_WIDTH-1:0]    vertex0_y,
	input  logic signed [COORD_WIDTH-1:0]    vertex0_z,
	input  logic signed [COORD_WIDTH-1:0]    vertex1_x,
	input  logic signed [COORD_WIDTH-1:0]    vertex1_y,
	input  logic signed [COORD_WIDTH-1:0]    vertex1_z,
	input  logic signed [COORD_WIDTH-1:0]    vertex2_x,
	input  logic signed [COORD_WIDTH-1:0]    vertex2_y,
	input  logic signed [COORD_WIDTH-1:0]    vertex2_z,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [COORD_WIDTH-1:0]    out_vertex0_x,
	output logic signed [COORD_WIDTH-1:0]    out_vertex0_y,
	output logic signed [COORD_WIDTH-1:0]    out_vertex0_z,
	output logic signed [COORD_WIDTH-1:0]    out_vertex1_x,
	output logic signed [COORD_WIDTH-1:0]    out_vertex1_y,
	output logic signed [COORD_WIDTH-1:0]    out_vertex1_z,
	output logic signed [COORD_WIDTH-1:0]    out_vertex2_x,
	output logic signed [COORD_WIDTH-1:0]    out_vertex2_y,
	output logic signed [COORD_WIDTH-1:0]    out_vertex2_z,
	output logic                             last_of_run
);

	localparam int W          = COORD_WIDTH;
	localparam int FB         = tpc_pkg::FRAC_BITS;
	localparam int SW         = 2 * W + 2;        // sum of squares
	localparam int K          = W + 1;            // root iterations
	localparam int LW         = W + 1;            // normal length
	localparam int NW         = W + FB;           // divider numerator
	localparam int UW         = FB + 2;           // unit normal component
	localparam int MW         = W + UW;           // u * coordinate
	localparam int UPW        = MW + 2;           // plane offset
	localparam int DW         = MW + 3;           // signed distance
	localparam int DENW       = DW + 1;
	localparam int QW         = FB;               // line parameter t
	localparam int DIV_STEPS  = 2;
	localparam int DIV_STAGES = QW / DIV_STEPS;
	localparam int PW         = W + QW + 2;       // (b - a) * t
	localparam int XW         = PW - FB;
	localparam int SUMW       = XW + 1;
	localparam int CW         = $clog2(NW);

	// setup sequencer states
	localparam logic [2:0] ST_SQ    = 3'd0;
	localparam logic [2:0] ST_ROOT  = 3'd1;
	localparam logic [2:0] ST_DLOAD = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_DNEXT = 3'd4;
	localparam logic [2:0] ST_DOT   = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	typedef logic [2:0][W-1:0] vec_t;
	typedef vec_t [2:0] face_t;

	typedef struct packed {
		vec_t            a;
		vec_t            b;
		logic [DENW-1:0] den;
		logic [DENW-1:0] rem;
		logic [QW-1:0]   q;
	} lane_t;

	typedef struct packed {
		logic [1:0] mode;
		vec_t       s0;
		vec_t       s1;
		vec_t       s2;
	} tri_t;

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic [W-1:0] pp_q [3];
	logic [W-1:0] pn_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pp_q[0] <= '0;
			pp_q[1] <= '0;
			pp_q[2] <= tpc_pkg::POINT_Z_RESET[W-1:0];
			pn_q[0] <= '0;
			pn_q[1] <= '0;
			pn_q[2] <= tpc_pkg::NORMAL_Z_RESET[W-1:0];
		end else if (cfg_write) begin
			case (cfg_index)
				tpc_pkg::REG_POINT_X:  pp_q[0] <= cfg_data;
				tpc_pkg::REG_POINT_Y:  pp_q[1] <= cfg_data;
				tpc_pkg::REG_POINT_Z:  pp_q[2] <= cfg_data;
				tpc_pkg::REG_NORMAL_X: pn_q[0] <= cfg_data;
				tpc_pkg::REG_NORMAL_Y: pn_q[1] <= cfg_data;
				tpc_pkg::REG_NORMAL_Z: pn_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// setup: S = |n|^2, L = isqrt(S), u_i = n_i * 2^16 / L, up = u . p
	// ------------------------------------------------------------------
	logic [2:0]             st_q;
	logic [CW-1:0]          cnt_q;
	logic [1:0]             idx_q;
	logic [SW-1:0]          acc_q;
	logic [SW-1:0]          root_q;
	logic [NW-1:0]          num_q;
	logic [LW-1:0]          rem_q;
	logic [UW-2:0]          quo_q;
	logic signed [UW-1:0]   u_q [3];
	logic signed [UPW-1:0]  up_q;
	logic                   zero_q;

	logic [W-1:0]           sel_n;
	logic [W-1:0]           n_mag;
	logic [2*W-1:0]         n_sq;
	logic [SW-1:0]          bitv;
	logic [SW-1:0]          root_try;
	logic [LW-1:0]          len;
	logic [LW:0]            div_r2;
	logic                   div_bit;
	logic [UW-1:0]          u_new;
	logic signed [MW-1:0]   up_prod;

	always_comb begin
		sel_n    = pn_q[idx_q];
		n_mag    = sel_n[W-1] ? (~sel_n + 1'b1) : sel_n;
		n_sq     = n_mag * n_mag;
		bitv     = SW'(1) << {cnt_q, 1'b0};
		root_try = root_q + bitv;
		len      = root_q[LW-1:0];
		div_r2   = {rem_q, num_q[NW-1]};
		div_bit  = (div_r2 >= {1'b0, len});
		u_new    = sel_n[W-1] ? (~{1'b0, quo_q} + 1'b1) : {1'b0, quo_q};
		up_prod  = u_q[idx_q] * $signed(pp_q[idx_q]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_SQ;
			idx_q  <= '0;
			cnt_q  <= '0;
			acc_q  <= '0;
			zero_q <= 1'b0;
		end else if (cfg_write) begin
			st_q  <= ST_SQ;
			idx_q <= '0;
			acc_q <= '0;
		end else begin
			case (st_q)
				ST_SQ: begin
					acc_q <= acc_q + SW'(n_sq);
					if (idx_q == 2'd2) begin
						st_q   <= ST_ROOT;
						idx_q  <= '0;
						cnt_q  <= CW'(K - 1);
						root_q <= '0;
					end else begin
						idx_q <= idx_q + 2'd1;
					end
				end
				ST_ROOT: begin
					if (acc_q >= root_try) begin
						acc_q  <= acc_q - root_try;
						root_q <= (root_q >> 1) + bitv;
					end else begin
						root_q <= root_q >> 1;
					end
					if (cnt_q == '0)
						st_q <= ST_DLOAD;
					else
						cnt_q <= cnt_q - 1'b1;
				end
				ST_DLOAD: begin
					if (len == '0) begin
						zero_q <= 1'b1;
						st_q   <= ST_DONE;
					end else begin
						zero_q <= 1'b0;
						num_q  <= {n_mag, {FB{1'b0}}};
						rem_q  <= '0;
						quo_q  <= '0;
						cnt_q  <= CW'(NW - 1);
						st_q   <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q <= div_bit ? LW'(div_r2 - {1'b0, len}) : div_r2[LW-1:0];
					num_q <= num_q << 1;
					quo_q <= {quo_q[UW-3:0], div_bit};
					if (cnt_q == '0)
						st_q <= ST_DNEXT;
					else
						cnt_q <= cnt_q - 1'b1;
				end
				ST_DNEXT: begin
					u_q[idx_q] <= $signed(u_new);
					if (idx_q == 2'd2) begin
						idx_q <= '0;
						up_q  <= '0;
						st_q  <= ST_DOT;
					end else begin
						idx_q <= idx_q + 2'd1;
						st_q  <= ST_DLOAD;
					end
				end
				ST_DOT: begin
					up_q <= up_q + UPW'(up_prod);
					if (idx_q == 2'd2)
						st_q <= ST_DONE;
					else
						idx_q <= idx_q + 2'd1;
				end
				ST_DONE: ;
				default: st_q <= ST_SQ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// pipeline control: one enable, set by the output register
	// ------------------------------------------------------------------
	logic  adv;
	logic  ob_vld_q, ob_two_q, ob_idx_q;
	face_t ob_f0_q, ob_f1_q;

	assign adv      = !ob_vld_q || (out_ready && (ob_idx_q || !ob_two_q));
	assign in_ready = adv && (st_q == ST_DONE);

	// s1: register vertices and the nine u_k * v_jk products
	vec_t                 vin [3];
	vec_t                 v_s1 [3];
	logic signed [MW-1:0] prod_s1 [3][3];
	logic                 vld_s1;

	assign vin[0] = {vertex0_z, vertex0_y, vertex0_x};
	assign vin[1] = {vertex1_z, vertex1_y, vertex1_x};
	assign vin[2] = {vertex2_z, vertex2_y, vertex2_x};

	// s2: signed distances d_j = u . v_j - u . p
	logic signed [DW-1:0] d_s2 [3];
	vec_t                 v_s2 [3];
	logic                 vld_s2;

	// s3: classification and edge setup
	tri_t             tri_s3;
	lane_t [1:0]      lane_s3;
	logic             vld_s3;

	// s4..s11: t = da * 2^16 / (da - db), two bits per stage
	tri_t             dt_s [DIV_STAGES];
	lane_t [1:0]      dl_s [DIV_STAGES];
	logic [DIV_STAGES-1:0] dv_s;

	// s12: (b - a) * t, s13: intersection points
	tri_t                 tri_s12;
	vec_t                 ma_s12 [2];
	logic signed [PW-1:0] mp_s12 [2][3];
	logic                 vld_s12;
	tri_t                 tri_s13;
	vec_t                 x_s13 [2];
	logic                 vld_s13;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			dv_s    <= '0;
			vld_s12 <= 1'b0;
			vld_s13 <= 1'b0;
		end else if (adv) begin
			vld_s1  <= in_valid && in_ready;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			dv_s    <= {dv_s[DIV_STAGES-2:0], vld_s3};
			vld_s12 <= dv_s[DIV_STAGES-1];
			vld_s13 <= vld_s12;
		end
	end

	function automatic vec_t sel3(vec_t a, vec_t b, vec_t c, logic [1:0] i);
		vec_t r;
		case (i)
			2'd0:    r = a;
			2'd1:    r = b;
			default: r = c;
		endcase
		return r;
	endfunction

	function automatic logic signed [DW-1:0] seld(logic signed [DW-1:0] a,
			logic signed [DW-1:0] b, logic signed [DW-1:0] c, logic [1:0] i);
		logic signed [DW-1:0] r;
		case (i)
			2'd0:    r = a;
			2'd1:    r = b;
			default: r = c;
		endcase
		return r;
	endfunction

	function automatic lane_t div_step(lane_t l);
		logic [DENW:0] r2;
		logic          qb;
		r2 = {l.rem, 1'b0};
		qb = (r2 >= {1'b0, l.den});
		if (qb)
			r2 = r2 - {1'b0, l.den};
		l.rem = r2[DENW-1:0];
		l.q   = {l.q[QW-2:0], qb};
		return l;
	endfunction

	function automatic logic [W-1:0] sat(logic signed [SUMW-1:0] s);
		logic [W-1:0] r;
		if (s[SUMW-1:W-1] == '0 || s[SUMW-1:W-1] == '1)
			r = s[W-1:0];
		else if (s[SUMW-1])
			r = {1'b1, {(W-1){1'b0}}};
		else
			r = {1'b0, {(W-1){1'b1}}};
		return r;
	endfunction

	// s1 / s2 payload
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < 3; j++) begin
				v_s1[j] <= vin[j];
				for (int k = 0; k < 3; k++)
					prod_s1[j][k] <= u_q[k] * $signed(vin[j][k]);
				v_s2[j] <= v_s1[j];
				d_s2[j] <= DW'(prod_s1[j][0]) + DW'(prod_s1[j][1])
					+ DW'(prod_s1[j][2]) - DW'(up_q);
			end
		end
	end

	// s3: pick inside/outside vertices in input order
	logic [2:0]           ins;
	logic [1:0]           i0, i1, o0, o1, num_in;
	logic [1:0]           mode_c;
	tri_t                 tri_c;
	lane_t [1:0]          lane_c;
	logic [1:0]           la_i [2];
	logic [1:0]           lb_i [2];
	logic signed [DW-1:0] da, db;

	always_comb begin
		for (int j = 0; j < 3; j++)
			ins[j] = !d_s2[j][DW-1];
		num_in = 2'(ins[0]) + 2'(ins[1]) + 2'(ins[2]);
		i0 = ins[0] ? 2'd0 : (ins[1] ? 2'd1 : 2'd2);
		i1 = ins[0] ? (ins[1] ? 2'd1 : 2'd2) : 2'd2;
		o0 = !ins[0] ? 2'd0 : (!ins[1] ? 2'd1 : 2'd2);
		o1 = !ins[0] ? (!ins[1] ? 2'd1 : 2'd2) : 2'd2;
		if (zero_q || ins == 3'b000)
			mode_c = tpc_pkg::MODE_NONE;
		else if (ins == 3'b111)
			mode_c = tpc_pkg::MODE_ALL;
		else if (num_in == 2'd1)
			mode_c = tpc_pkg::MODE_ONE;
		else
			mode_c = tpc_pkg::MODE_TWO;

		tri_c.mode = mode_c;
		tri_c.s0   = sel3(v_s2[0], v_s2[1], v_s2[2], i0);
		tri_c.s1   = sel3(v_s2[0], v_s2[1], v_s2[2], i1);
		tri_c.s2   = v_s2[2];

		// edge 0 is (I0, O0); edge 1 is (I0, O1) or (I1, O0)
		la_i[0] = i0;
		lb_i[0] = o0;
		la_i[1] = (mode_c == tpc_pkg::MODE_TWO) ? i1 : i0;
		lb_i[1] = (mode_c == tpc_pkg::MODE_TWO) ? o0 : o1;
		for (int l = 0; l < 2; l++) begin
			da = seld(d_s2[0], d_s2[1], d_s2[2], la_i[l]);
			db = seld(d_s2[0], d_s2[1], d_s2[2], lb_i[l]);
			lane_c[l].a   = sel3(v_s2[0], v_s2[1], v_s2[2], la_i[l]);
			lane_c[l].b   = sel3(v_s2[0], v_s2[1], v_s2[2], lb_i[l]);
			lane_c[l].den = DENW'(da) - DENW'(db);
			lane_c[l].rem = DENW'(da);
			lane_c[l].q   = '0;
		end
	end

	// divider stages
	lane_t [1:0] dnx [DIV_STAGES];

	always_comb begin
		for (int k = 0; k < DIV_STAGES; k++) begin
			for (int l = 0; l < 2; l++) begin
				dnx[k][l] = (k == 0) ? lane_s3[l] : dl_s[k-1][l];
				for (int s = 0; s < DIV_STEPS; s++)
					dnx[k][l] = div_step(dnx[k][l]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tri_s3  <= tri_c;
			lane_s3 <= lane_c;
			dt_s[0] <= tri_s3;
			dl_s[0] <= dnx[0];
			for (int k = 1; k < DIV_STAGES; k++) begin
				dt_s[k] <= dt_s[k-1];
				dl_s[k] <= dnx[k];
			end
		end
	end

	// s12 / s13
	logic signed [W:0]      diff [2][3];
	logic signed [PW-1:0]   mprod [2][3];
	logic signed [PW-1:0]   adj;
	logic signed [SUMW-1:0] xsum;
	vec_t                   x_c [2];

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			for (int i = 0; i < 3; i++) begin
				diff[l][i] = (W+1)'($signed(dl_s[DIV_STAGES-1][l].b[i]))
					- (W+1)'($signed(dl_s[DIV_STAGES-1][l].a[i]));
				mprod[l][i] = diff[l][i] * $signed({1'b0, dl_s[DIV_STAGES-1][l].q});
			end
		end
		for (int l = 0; l < 2; l++) begin
			for (int i = 0; i < 3; i++) begin
				// truncate toward zero on the divide by 2^16
				adj = mp_s12[l][i] + (mp_s12[l][i][PW-1] ?
					PW'((1 << FB) - 1) : PW'(0));
				xsum = SUMW'($signed(ma_s12[l][i])) + SUMW'($signed(adj[PW-1:FB]));
				x_c[l][i] = sat(xsum);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tri_s12 <= dt_s[DIV_STAGES-1];
			for (int l = 0; l < 2; l++) begin
				ma_s12[l] <= dl_s[DIV_STAGES-1][l].a;
				x_s13[l]  <= x_c[l];
				for (int i = 0; i < 3; i++)
					mp_s12[l][i] <= mprod[l][i];
			end
			tri_s13 <= tri_s12;
		end
	end

	// ------------------------------------------------------------------
	// output register: zero, one or two triangles per input
	// ------------------------------------------------------------------
	face_t f0_c, f1_c;

	always_comb begin
		f1_c[0] = tri_s13.s1;
		f1_c[1] = x_s13[0];
		f1_c[2] = x_s13[1];
		case (tri_s13.mode)
			tpc_pkg::MODE_ONE: begin
				f0_c[0] = tri_s13.s0;
				f0_c[1] = x_s13[0];
				f0_c[2] = x_s13[1];
			end
			tpc_pkg::MODE_TWO: begin
				f0_c[0] = tri_s13.s0;
				f0_c[1] = tri_s13.s1;
				f0_c[2] = x_s13[0];
			end
			default: begin
				f0_c[0] = tri_s13.s0;
				f0_c[1] = tri_s13.s1;
				f0_c[2] = tri_s13.s2;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_vld_q <= 1'b0;
			ob_two_q <= 1'b0;
			ob_idx_q <= 1'b0;
		end else if (adv) begin
			ob_vld_q <= vld_s13 && (tri_s13.mode != tpc_pkg::MODE_NONE);
			ob_two_q <= (tri_s13.mode == tpc_pkg::MODE_TWO);
			ob_idx_q <= 1'b0;
		end else if (out_ready) begin
			// first beat of a split triangle taken
			ob_idx_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ob_f0_q <= f0_c;
			ob_f1_q <= f1_c;
		end
	end

	face_t cur;

	assign cur           = ob_idx_q ? ob_f1_q : ob_f0_q;
	assign out_valid     = ob_vld_q;
	assign last_of_run   = !ob_two_q || ob_idx_q;
	assign out_vertex0_x = cur[0][0];
	assign out_vertex0_y = cur[0][1];
	assign out_vertex0_z = cur[0][2];
	assign out_vertex1_x = cur[1][0];
	assign out_vertex1_y = cur[1][1];
	assign out_vertex1_z = cur[1][2];
	assign out_vertex2_x = cur[2][0];
	assign out_vertex2_y = cur[2][1];
	assign out_vertex2_z = cur[2][2];

endmodule

// ===== hw/rtl/tpc_checker.sv =====
// ----------------------------------------------------------------------------
// tpc_checker: port-level checks for the triangle plane clipper
// Watches setup, split-triangle beats and output stalls.
// ----------------------------------------------------------------------------
module tpc_checker #(
	parameter int COORD_WIDTH = tpc_pkg::COORD_WIDTH
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   cfg_write,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic                   last_of_run,
	input logic [COORD_WIDTH-1:0] out_vertex0_x
);

	// a register write starts a multi-cycle setup pass
	a_setup_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_write |=> !in_ready ##1 !in_ready)
		else $error("input taken during setup");

	// the first beat of a split triangle is followed by its last beat
	a_split_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_run |=> out_valid && last_of_run)
		else $error("second triangle missing");

	// a stalled output register stalls the whole pipeline
	a_stall_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output stalled");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_vertex0_x)
			&& $stable(last_of_run))
		else $error("output beat changed while stalled");

endmodule

bind triangle_plane_clip tpc_checker #(.COORD_WIDTH(COORD_WIDTH)) u_tpc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cfg_write     (cfg_write),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.last_of_run   (last_of_run),
	.out_vertex0_x (out_vertex0_x)
);
